/* hdl/mcmp_pkg.sv */
package mcmp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SINGLE = 2'd2,
        PH_SECOND = 2'd3
    } t_phase;

    // command nibbles (upper half of a status byte)
    localparam logic [3:0] CMD_NOTE_OFF  = 4'h8;
    localparam logic [3:0] CMD_BEND      = 4'hE;
    localparam logic [3:0] CMD_NOTE_ON   = 4'h9;
    localparam logic [3:0] CMD_CONTROL   = 4'hB;
    localparam logic [3:0] CMD_PROGRAM   = 4'hC;
    localparam logic [3:0] CMD_CHAN_PRES = 4'hD;

    // position of the current word inside a resent run
    localparam logic [1:0] IDX_STATUS = 2'd0;
    localparam logic [1:0] IDX_DATA1  = 2'd1;
    localparam logic [1:0] IDX_DATA2  = 2'd2;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic [2:0] kind;
        logic [4:0] chan;
        logic       mapper;
        logic       three;
    } t_msg;

endpackage

/* hdl/midi_channel_message_parser.sv */
// An input word is registered in the input register and decoded from there; the first
// thru word of a completed message then comes out of the result register.
// Throughput: one input word per cycle while o_stall is low; a completed message
// holds the output register for its 2 or 3 thru words: the only stall source.
// Reset (synchronous, i_rst_n low): parser returns to waiting for status, held
// command, channel and first data clear to zero, no words pending.
module midi_channel_message_parser
    import mcmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_thru_byte,
    output logic        o_last_of_run,
    output logic [2:0]  o_msg_kind,
    output logic [4:0]  o_chan_number,
    output logic [6:0]  o_first_data,
    output logic [6:0]  o_second_data,
    output logic [13:0] o_bend_value,
    output logic        o_to_mapper
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // parser state
    t_phase     r_phase, n_phase;
    logic [3:0] r_cmd, n_cmd;
    logic [3:0] r_chan, n_chan;
    logic [6:0] r_first, n_first;

    // result register
    logic       r_run_valid;
    logic [1:0] r_idx;
    t_msg       r_msg;

    logic       produce;
    t_msg       n_msg;
    logic       out_fire;
    logic       out_last;
    logic       run_free;
    logic       s1_adv;
    logic       in_fire;

    assign out_last = (r_idx == IDX_DATA2) || (r_idx == IDX_DATA1 && !r_msg.three);
    assign out_fire = r_run_valid && !i_stall;
    assign run_free = !r_run_valid || (out_fire && out_last);
    assign s1_adv   = !r_in_valid || !produce || run_free;
    assign o_stall  = r_in_valid && !s1_adv;
    assign in_fire  = i_valid && !o_stall;

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_chan   = r_chan;
        n_first  = r_first;
        produce  = 1'b0;
        n_msg.status = {r_cmd, r_chan};
        n_msg.kind   = r_cmd[2:0];
        n_msg.chan   = {1'b0, r_chan} + 5'd1;
        n_msg.d1     = r_first;
        n_msg.d2     = r_in_byte[6:0];
        n_msg.mapper = 1'b0;
        n_msg.three  = 1'b1;
        if (r_in_byte[7]) begin
            n_cmd   = r_in_byte[7:4];
            n_chan  = r_in_byte[3:0];
            n_phase = (r_in_byte[7:4] == CMD_PROGRAM || r_in_byte[7:4] == CMD_CHAN_PRES)
                      ? PH_SINGLE : PH_FIRST;
        end else begin
            unique case (r_phase)
                PH_FIRST: begin
                    n_first = r_in_byte[6:0];
                    n_phase = PH_SECOND;
                end
                PH_SINGLE: begin
                    n_phase      = PH_IDLE;
                    produce      = (r_cmd == CMD_PROGRAM || r_cmd == CMD_CHAN_PRES);
                    n_msg.d1     = r_in_byte[6:0];
                    n_msg.d2     = 7'd0;
                    n_msg.three  = 1'b0;
                    n_msg.mapper = (r_cmd == CMD_PROGRAM);
                end
                PH_SECOND: begin
                    n_phase      = PH_IDLE;
                    // system commands (0xF) fall out here with no thru words
                    produce      = (r_cmd >= CMD_NOTE_OFF) && (r_cmd <= CMD_BEND)
                                   && (r_cmd != CMD_PROGRAM) && (r_cmd != CMD_CHAN_PRES);
                    n_msg.mapper = (r_cmd == CMD_NOTE_ON || r_cmd == CMD_CONTROL);
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_IDLE;
            r_cmd       <= 4'd0;
            r_chan      <= 4'd0;
            r_first     <= 7'd0;
            r_run_valid <= 1'b0;
            r_idx       <= IDX_STATUS;
        end else begin
            if (s1_adv) begin
                r_in_valid <= in_fire;
            end
            if (r_in_valid && s1_adv) begin
                r_phase <= n_phase;
                r_cmd   <= n_cmd;
                r_chan  <= n_chan;
                r_first <= n_first;
            end
            if (r_in_valid && produce && run_free) begin
                r_run_valid <= 1'b1;
                r_idx       <= IDX_STATUS;
            end else if (out_fire) begin
                if (out_last) begin
                    r_run_valid <= 1'b0;
                end
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_rx_byte;
        end
        if (r_in_valid && produce && run_free) begin
            r_msg <= n_msg;
        end
    end

    always_comb begin
        case (r_idx)
            IDX_STATUS: o_thru_byte = r_msg.status;
            IDX_DATA1:  o_thru_byte = {1'b0, r_msg.d1};
            default:    o_thru_byte = {1'b0, r_msg.d2};
        endcase
    end

    assign o_valid       = r_run_valid;
    assign o_last_of_run = out_last;
    assign o_msg_kind    = r_msg.kind;
    assign o_chan_number = r_msg.chan;
    assign o_first_data  = r_msg.d1;
    assign o_second_data = r_msg.d2;
    assign o_bend_value  = {r_msg.d2, r_msg.d1};
    assign o_to_mapper   = r_msg.mapper;

endmodule
